// File: rtl/core/assert_macros.svh
// Assertion macros shared by the vector cross/dot/angle RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VCDA_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("vcda assertion failed");
`define VCDA_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vcda implication failed");
`else
`define VCDA_ASSERT(name, prop)
`define VCDA_ASSERT_IMP(name, ante, cons)
`endif
`endif

// File: rtl/core/vcda_pkg.sv
// Shared types and constants for the vector cross/dot/angle pipeline.
// No dependencies.
`default_nettype none
package vcda_pkg;
   localparam int Q_BITS     = 15;  // quotient bits of the unit-range results
   localparam int FRAC_SHIFT = 30;  // 2^30 scales the numerator so the quotient comes out in Q0.15
   localparam int OUT_W      = 33;  // width of cross and dot result fields
   localparam int COS_W      = 16;

   typedef struct packed {
      logic dneg;   // dot product negative
      logic degen;  // a vector of zero length
   } flags_type;
endpackage
`default_nettype wire

// File: rtl/core/vcda_front.sv
// Front end: component products, then cross, dot and squared lengths.
// Two register stages; uses vcda_pkg.
`default_nettype none
module vcda_front #(
   parameter int W      = 16,
   parameter int SIDE_W = 8*W+5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic signed [W-1:0]   ax,
   input  wire logic signed [W-1:0]   ay,
   input  wire logic signed [W-1:0]   az,
   input  wire logic signed [W-1:0]   bx,
   input  wire logic signed [W-1:0]   by,
   input  wire logic signed [W-1:0]   bz,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [2*W-1:0]             la,
   output logic [2*W-1:0]             lb,
   output logic [2*W-1:0]             dmag,
   output logic [SIDE_W-1:0]          side,
   output vcda_pkg::flags_type        flags
);
   import vcda_pkg::*;

   localparam int PW = 2*W;

   logic va_ff, vb_ff, rdy_a, rdy_b;
   logic signed [PW-1:0] pxx_ff, pyy_ff, pzz_ff;
   logic signed [PW-1:0] pyz_ff, pzy_ff, pzx_ff, pxz_ff, pxy_ff, pyx_ff;
   logic signed [PW-1:0] sax_ff, say_ff, saz_ff, sbx_ff, sby_ff, sbz_ff;

   logic signed [PW:0]   cx_in, cy_in, cz_in;
   logic signed [PW+1:0] dot_in;
   logic [PW-1:0]        la_in, lb_in, dmag_in;
   logic [PW-1:0]        la_ff, lb_ff, dmag_ff;
   logic [SIDE_W-1:0]    side_ff;
   flags_type            flags_in, flags_ff;

   assign rdy_b    = !vb_ff || out_ready;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= in_valid;
         if (rdy_b) vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && rdy_a) begin
         pxx_ff <= ax * bx;
         pyy_ff <= ay * by;
         pzz_ff <= az * bz;
         pyz_ff <= ay * bz;
         pzy_ff <= az * by;
         pzx_ff <= az * bx;
         pxz_ff <= ax * bz;
         pxy_ff <= ax * by;
         pyx_ff <= ay * bx;
         sax_ff <= ax * ax;
         say_ff <= ay * ay;
         saz_ff <= az * az;
         sbx_ff <= bx * bx;
         sby_ff <= by * by;
         sbz_ff <= bz * bz;
      end
   end

   always_comb begin
      cx_in  = (PW+1)'(pyz_ff) - (PW+1)'(pzy_ff);
      cy_in  = (PW+1)'(pzx_ff) - (PW+1)'(pxz_ff);
      cz_in  = (PW+1)'(pxy_ff) - (PW+1)'(pyx_ff);
      dot_in = (PW+2)'(pxx_ff) + (PW+2)'(pyy_ff) + (PW+2)'(pzz_ff);
      // squares are non-negative and at most 2^(2W-2), so the sum stays in 2W bits
      la_in  = PW'($unsigned(sax_ff)) + PW'($unsigned(say_ff)) + PW'($unsigned(saz_ff));
      lb_in  = PW'($unsigned(sbx_ff)) + PW'($unsigned(sby_ff)) + PW'($unsigned(sbz_ff));
      flags_in.dneg  = dot_in[PW+1];
      flags_in.degen = (la_in == '0) || (lb_in == '0);
      dmag_in = dot_in[PW+1] ? PW'(-dot_in) : PW'(dot_in);
   end

   always_ff @(posedge clock) begin
      if (va_ff && rdy_b) begin
         la_ff    <= la_in;
         lb_ff    <= lb_in;
         dmag_ff  <= dmag_in;
         flags_ff <= flags_in;
         side_ff  <= {cx_in, cy_in, cz_in, dot_in};
      end
   end

   assign out_valid = vb_ff;
   assign la        = la_ff;
   assign lb        = lb_ff;
   assign dmag      = dmag_ff;
   assign side      = side_ff;
   assign flags     = flags_ff;
endmodule
`default_nettype wire

// File: rtl/core/vcda_mul.sv
// Wide products |a|^2|b|^2 and dot^2 from half-width partial products,
// then the Lagrange difference. Three register stages; uses vcda_pkg.
`default_nettype none
module vcda_mul #(
   parameter int W      = 16,
   parameter int SIDE_W = 8*W+5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [2*W-1:0]        la,
   input  wire logic [2*W-1:0]        lb,
   input  wire logic [2*W-1:0]        dmag,
   input  wire logic [SIDE_W-1:0]     side_in,
   input  vcda_pkg::flags_type        flags_in,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [4*W-1:0]             prod,
   output logic [4*W-1:0]             d2,
   output logic [4*W-1:0]             sq,
   output logic [SIDE_W-1:0]          side_out,
   output vcda_pkg::flags_type        flags_out
);
   import vcda_pkg::*;

   localparam int LW = 4*W;

   logic va_ff, vb_ff, vc_ff, rdy_a, rdy_b, rdy_c;
   logic [2*W-1:0] pl_ll_ff, pl_lh_ff, pl_hl_ff, pl_hh_ff;
   logic [2*W-1:0] pd_ll_ff, pd_lh_ff, pd_hh_ff;
   logic [LW-1:0]  prod_in, d2_in, prod_ff, d2_ff, prod_c_ff, d2_c_ff, sq_ff;
   logic [SIDE_W-1:0] side_a_ff, side_b_ff, side_c_ff;
   flags_type flags_a_ff, flags_b_ff, flags_c_ff;

   assign rdy_c    = !vc_ff || out_ready;
   assign rdy_b    = !vb_ff || rdy_c;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= in_valid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
      end
   end

   // split each operand in halves of W bits
   always_ff @(posedge clock) begin
      if (in_valid && rdy_a) begin
         pl_ll_ff   <= la[W-1:0]   * lb[W-1:0];
         pl_lh_ff   <= la[W-1:0]   * lb[2*W-1:W];
         pl_hl_ff   <= la[2*W-1:W] * lb[W-1:0];
         pl_hh_ff   <= la[2*W-1:W] * lb[2*W-1:W];
         pd_ll_ff   <= dmag[W-1:0]   * dmag[W-1:0];
         pd_lh_ff   <= dmag[W-1:0]   * dmag[2*W-1:W];
         pd_hh_ff   <= dmag[2*W-1:W] * dmag[2*W-1:W];
         side_a_ff  <= side_in;
         flags_a_ff <= flags_in;
      end
   end

   always_comb begin
      prod_in = LW'(pl_ll_ff) + (LW'(pl_lh_ff) << W) + (LW'(pl_hl_ff) << W)
              + (LW'(pl_hh_ff) << (2*W));
      d2_in   = LW'(pd_ll_ff) + (LW'(pd_lh_ff) << (W+1)) + (LW'(pd_hh_ff) << (2*W));
   end

   always_ff @(posedge clock) begin
      if (va_ff && rdy_b) begin
         prod_ff    <= prod_in;
         d2_ff      <= d2_in;
         side_b_ff  <= side_a_ff;
         flags_b_ff <= flags_a_ff;
      end
   end

   // d2 never exceeds prod (Cauchy-Schwarz), so the difference is the squared cross length
   always_ff @(posedge clock) begin
      if (vb_ff && rdy_c) begin
         prod_c_ff  <= prod_ff;
         d2_c_ff    <= d2_ff;
         sq_ff      <= prod_ff - d2_ff;
         side_c_ff  <= side_b_ff;
         flags_c_ff <= flags_b_ff;
      end
   end

   assign out_valid = vc_ff;
   assign prod      = prod_c_ff;
   assign d2        = d2_c_ff;
   assign sq        = sq_ff;
   assign side_out  = side_c_ff;
   assign flags_out = flags_c_ff;
endmodule
`default_nettype wire

// File: rtl/core/vcda_root_stage.sv
// One bit of the quotient-root search for cosine and sine:
// largest q with q*q*prod <= num, kept as remainder and q*prod. Uses vcda_pkg.
`default_nettype none
module vcda_root_stage #(
   parameter int W      = 16,
   parameter int BIT    = 14,
   parameter int SIDE_W = 8*W+5,
   parameter int RW     = 4*W+31
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [4*W-1:0]             prod_in,
   input  wire logic [RW-1:0]              rc_in,
   input  wire logic [RW-1:0]              tc_in,
   input  wire logic [vcda_pkg::Q_BITS-1:0] qc_in,
   input  wire logic [RW-1:0]              rs_in,
   input  wire logic [RW-1:0]              ts_in,
   input  wire logic [vcda_pkg::Q_BITS-1:0] qs_in,
   input  wire logic [SIDE_W-1:0]          side_in,
   input  vcda_pkg::flags_type             flags_in,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [4*W-1:0]                  prod_out,
   output logic [RW-1:0]                   rc_out,
   output logic [RW-1:0]                   tc_out,
   output logic [vcda_pkg::Q_BITS-1:0]     qc_out,
   output logic [RW-1:0]                   rs_out,
   output logic [RW-1:0]                   ts_out,
   output logic [vcda_pkg::Q_BITS-1:0]     qs_out,
   output logic [SIDE_W-1:0]               side_out,
   output vcda_pkg::flags_type             flags_out
);
   import vcda_pkg::*;

   logic v_ff;
   logic [RW-1:0] pe, trial_c, trial_s, rc_in_n, tc_in_n, rs_in_n, ts_in_n;
   logic take_c, take_s;
   logic [Q_BITS-1:0] qc_in_n, qs_in_n;
   logic [4*W-1:0] prod_ff;
   logic [RW-1:0] rc_ff, tc_ff, rs_ff, ts_ff;
   logic [Q_BITS-1:0] qc_ff, qs_ff;
   logic [SIDE_W-1:0] side_ff;
   flags_type flags_ff;

   assign in_ready = !v_ff || out_ready;

   // (q + 2^b)^2 p - q^2 p = 2^(b+1) (q p) + 2^(2b) p
   always_comb begin
      pe      = RW'(prod_in);
      trial_c = (tc_in << (BIT+1)) + (pe << (2*BIT));
      trial_s = (ts_in << (BIT+1)) + (pe << (2*BIT));
      take_c  = trial_c <= rc_in;
      take_s  = trial_s <= rs_in;
      rc_in_n = take_c ? rc_in - trial_c : rc_in;
      tc_in_n = take_c ? tc_in + (pe << BIT) : tc_in;
      qc_in_n = qc_in | (Q_BITS'(take_c) << BIT);
      rs_in_n = take_s ? rs_in - trial_s : rs_in;
      ts_in_n = take_s ? ts_in + (pe << BIT) : ts_in;
      qs_in_n = qs_in | (Q_BITS'(take_s) << BIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff  <= prod_in;
         rc_ff    <= rc_in_n;
         tc_ff    <= tc_in_n;
         qc_ff    <= qc_in_n;
         rs_ff    <= rs_in_n;
         ts_ff    <= ts_in_n;
         qs_ff    <= qs_in_n;
         side_ff  <= side_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = v_ff;
   assign prod_out  = prod_ff;
   assign rc_out    = rc_ff;
   assign tc_out    = tc_ff;
   assign qc_out    = qc_ff;
   assign rs_out    = rs_ff;
   assign ts_out    = ts_ff;
   assign qs_out    = qs_ff;
   assign side_out  = side_ff;
   assign flags_out = flags_ff;
endmodule
`default_nettype wire

// File: rtl/core/vector_cross_dot_angle.sv
// Top level: cross, dot, cosine and sine of two 3D Q8.8 vectors.
// Uses vcda_pkg, vcda_front, vcda_mul, vcda_root_stage, assert_macros.svh.
//
//   channel | ports | direction | word
//   req     | req_* | in        | two vectors, six components
//   rsp     | rsp_* | out       | cross, dot, cosine, sine, degenerate flag
//
// One word per cycle unless rsp_ready stalls it. Stages: 2 front, 3 wide multiply, 15 root
// search stages (one quotient bit each), 1 output register.
// Reset clears every stage valid bit; no clearing pass.
// Each stage holds its word while the next is full and stalled; bubbles close up.
`default_nettype none
`include "assert_macros.svh"
module vector_cross_dot_angle #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_first_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_first_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_first_z,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_second_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_second_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_second_z,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [vcda_pkg::OUT_W-1:0]      rsp_cross_x,
   output logic signed [vcda_pkg::OUT_W-1:0]      rsp_cross_y,
   output logic signed [vcda_pkg::OUT_W-1:0]      rsp_cross_z,
   output logic signed [vcda_pkg::OUT_W-1:0]      rsp_dot_product,
   output logic signed [vcda_pkg::COS_W-1:0]      rsp_cosine,
   output logic [vcda_pkg::Q_BITS-1:0]            rsp_sine,
   output logic                                   rsp_degenerate
);
   import vcda_pkg::*;

   localparam int W      = COMPONENT_WIDTH;
   localparam int CW     = 2*W+1;
   localparam int DW     = 2*W+2;
   localparam int SIDE_W = 3*CW + DW;
   localparam int RW     = 4*W+31;
   localparam int NST    = Q_BITS;

   logic              f_valid, f_ready;
   logic [2*W-1:0]    f_la, f_lb, f_dmag;
   logic [SIDE_W-1:0] f_side;
   flags_type         f_flags;

   logic              m_valid, m_ready;
   logic [4*W-1:0]    m_prod, m_d2, m_sq;
   logic [SIDE_W-1:0] m_side;
   flags_type         m_flags;

   logic              s_valid [NST+1];
   logic              s_ready [NST+1];
   logic [4*W-1:0]    s_prod  [NST+1];
   logic [RW-1:0]     s_rc    [NST+1];
   logic [RW-1:0]     s_tc    [NST+1];
   logic [Q_BITS-1:0] s_qc    [NST+1];
   logic [RW-1:0]     s_rs    [NST+1];
   logic [RW-1:0]     s_ts    [NST+1];
   logic [Q_BITS-1:0] s_qs    [NST+1];
   logic [SIDE_W-1:0] s_side  [NST+1];
   flags_type         s_flags [NST+1];

   vcda_front #(.W(W), .SIDE_W(SIDE_W)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .ax(req_first_x), .ay(req_first_y), .az(req_first_z),
      .bx(req_second_x), .by(req_second_y), .bz(req_second_z),
      .out_valid(f_valid), .out_ready(f_ready),
      .la(f_la), .lb(f_lb), .dmag(f_dmag), .side(f_side), .flags(f_flags)
   );

   vcda_mul #(.W(W), .SIDE_W(SIDE_W)) u_mul (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready),
      .la(f_la), .lb(f_lb), .dmag(f_dmag), .side_in(f_side), .flags_in(f_flags),
      .out_valid(m_valid), .out_ready(m_ready),
      .prod(m_prod), .d2(m_d2), .sq(m_sq), .side_out(m_side), .flags_out(m_flags)
   );

   // seed the search: remainder = numerator, q = 0
   assign s_valid[0] = m_valid;
   assign m_ready    = s_ready[0];
   assign s_prod[0]  = m_prod;
   assign s_rc[0]    = RW'(m_d2) << FRAC_SHIFT;
   assign s_tc[0]    = '0;
   assign s_qc[0]    = '0;
   assign s_rs[0]    = RW'(m_sq) << FRAC_SHIFT;
   assign s_ts[0]    = '0;
   assign s_qs[0]    = '0;
   assign s_side[0]  = m_side;
   assign s_flags[0] = m_flags;

   for (genvar k = 0; k < NST; k++) begin : g_root
      vcda_root_stage #(.W(W), .BIT(NST-1-k), .SIDE_W(SIDE_W), .RW(RW)) u_stage (
         .clock(clock), .reset(reset),
         .in_valid(s_valid[k]), .in_ready(s_ready[k]),
         .prod_in(s_prod[k]), .rc_in(s_rc[k]), .tc_in(s_tc[k]), .qc_in(s_qc[k]),
         .rs_in(s_rs[k]), .ts_in(s_ts[k]), .qs_in(s_qs[k]),
         .side_in(s_side[k]), .flags_in(s_flags[k]),
         .out_valid(s_valid[k+1]), .out_ready(s_ready[k+1]),
         .prod_out(s_prod[k+1]), .rc_out(s_rc[k+1]), .tc_out(s_tc[k+1]),
         .qc_out(s_qc[k+1]), .rs_out(s_rs[k+1]), .ts_out(s_ts[k+1]),
         .qs_out(s_qs[k+1]), .side_out(s_side[k+1]), .flags_out(s_flags[k+1])
      );
   end

   // output register
   logic                     out_v_ff;
   logic signed [CW-1:0]     cx, cy, cz;
   logic signed [DW-1:0]     dot;
   logic signed [CW+OUT_W-1:0] cx_ext, cy_ext, cz_ext;
   logic signed [DW+OUT_W-1:0] dot_ext;
   logic signed [COS_W-1:0]  cos_in;
   logic [Q_BITS-1:0]        sin_in;
   logic signed [OUT_W-1:0]  cx_ff, cy_ff, cz_ff, dot_ff;
   logic signed [COS_W-1:0]  cos_ff;
   logic [Q_BITS-1:0]        sin_ff;
   logic                     degen_ff;
   flags_type                fl;

   assign s_ready[NST] = !out_v_ff || rsp_ready;
   assign fl           = s_flags[NST];
   assign {cx, cy, cz, dot} = s_side[NST];

   always_comb begin
      // keep the low 33 bits of the exact value
      cx_ext  = (CW+OUT_W)'(cx);
      cy_ext  = (CW+OUT_W)'(cy);
      cz_ext  = (CW+OUT_W)'(cz);
      dot_ext = (DW+OUT_W)'(dot);
      if (fl.degen) begin
         cos_in = '0;
         sin_in = '0;
      end else begin
         cos_in = fl.dneg ? -$signed({1'b0, s_qc[NST]}) : $signed({1'b0, s_qc[NST]});
         sin_in = s_qs[NST];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (s_ready[NST]) begin
         out_v_ff <= s_valid[NST];
      end
   end

   always_ff @(posedge clock) begin
      if (s_valid[NST] && s_ready[NST]) begin
         cx_ff    <= cx_ext[OUT_W-1:0];
         cy_ff    <= cy_ext[OUT_W-1:0];
         cz_ff    <= cz_ext[OUT_W-1:0];
         dot_ff   <= dot_ext[OUT_W-1:0];
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
         degen_ff <= fl.degen;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_cross_x     = cx_ff;
   assign rsp_cross_y     = cy_ff;
   assign rsp_cross_z     = cz_ff;
   assign rsp_dot_product = dot_ff;
   assign rsp_cosine      = cos_ff;
   assign rsp_sine        = sin_ff;
   assign rsp_degenerate  = degen_ff;

   `VCDA_ASSERT_IMP(a_degen_zero, rsp_valid && rsp_degenerate, rsp_cosine == 0 && rsp_sine == 0)
   `VCDA_ASSERT_IMP(a_cos_range, rsp_valid, rsp_cosine != -16'sd32768)
   `VCDA_ASSERT_IMP(a_full_stall, !req_ready, rsp_valid && !rsp_ready)
endmodule
`default_nettype wire
